### rtl/core/evicting_event_ring_with_replay_unit_assert.svh
// Assertion macros shared by the event ring RTL.
// Depends on nothing; included by the top level only.
`ifndef EVICTING_EVENT_RING_WITH_REPLAY_UNIT_ASSERT_SVH
`define EVICTING_EVENT_RING_WITH_REPLAY_UNIT_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define EVRING_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define EVRING_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/evring_pkg.sv
// Shared constants and types for the event ring with replay.
// No dependencies; imported by evring_seq and the top level.
`default_nettype none

package evring_pkg;

    localparam int DEPTH     = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SEQ_W     = 64;
    localparam int PAY_W     = 32;
    localparam int ENTRY_W   = SEQ_W + PAY_W;
    localparam int CAP_W     = 6;
    localparam int BATCH_W   = 6;
    localparam int MODE_W    = 2;
    localparam int OCC_W     = 6;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

    // Operation selector carried in the input tuser
    localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPLAY = 2'd2;

    // Register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic             has_entry;
        logic [SEQ_W-1:0] out_seq;
        logic [PAY_W-1:0] out_payload;
        logic             last;
        logic             stored_without_eviction;
        logic             resume_held;
        logic [SEQ_W-1:0] window_min_seq;
        logic [SEQ_W-1:0] window_max_seq;
        logic             became_empty;
        logic [OCC_W-1:0] occupancy;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/evring_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none

module evring_ram #(
    parameter int Depth = 32,
    parameter int Width = 96
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/evring_seq.sv
// Sequencer of the event ring: push, pop batch and replay over the entry RAM.
// Depends on evring_pkg and evring_ram.
`default_nettype none

module evring_seq
    import evring_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CAP_W-1:0]   i_cap,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [MODE_W-1:0]  i_mode,
    input  wire logic [SEQ_W-1:0]   i_entry_seq,
    input  wire logic [PAY_W-1:0]   i_entry_payload,
    input  wire logic [BATCH_W-1:0] i_batch_limit,
    input  wire logic [SEQ_W-1:0]   i_resume_seq,
    input  wire logic               i_out_free,
    output logic                    o_emit,
    output t_result                 o_result
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WMIN = 5'b00010,
        S_WMAX = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SEQ_W-1:0]   r_high, n_high;
    logic [ADDR_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]   r_left, n_left;
    logic               r_pend, n_pend;
    logic               r_is_pop, n_is_pop;
    logic [SEQ_W-1:0]   r_since, n_since;
    logic [SEQ_W-1:0]   r_wmin, n_wmin;
    logic [SEQ_W-1:0]   r_wmax, n_wmax;
    logic               r_found, n_found;
    logic               r_hold_v, n_hold_v;
    logic [SEQ_W-1:0]   r_hold_seq, n_hold_seq;
    logic [PAY_W-1:0]   r_hold_pay, n_hold_pay;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_q;
    logic [SEQ_W-1:0]   q_seq;
    logic [PAY_W-1:0]   q_pay;

    logic               accept;
    logic [CNT_W-1:0]   cap_eff;
    logic               evict;
    logic [ADDR_W-1:0]  head_p;
    logic [CNT_W-1:0]   cnt_p;
    logic [CNT_W-1:0]   batch;
    logic [CNT_W-1:0]   take;
    logic [CNT_W-1:0]   cnt_m1;
    logic               found_empty;
    logic               lost;
    logic               match;
    logic               consume;
    logic               rd;

    evring_ram #(
        .Depth (DEPTH),
        .Width (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign q_seq = ram_q[SEQ_W-1:0];
    assign q_pay = ram_q[ENTRY_W-1:SEQ_W];

    assign o_in_ready = (r_state == S_IDLE) && i_out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        if (i_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (i_cap > CAP_W'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(i_cap);
        end
    end

    assign evict       = (r_count >= cap_eff);
    assign head_p      = evict ? r_head + ADDR_W'(1) : r_head;
    assign cnt_p       = evict ? r_count - CNT_W'(1) : r_count;
    assign batch       = CNT_W'(i_batch_limit);
    assign take        = (batch < r_count) ? batch : r_count;
    assign cnt_m1      = r_count - CNT_W'(1);
    assign found_empty = (r_high == '0) || (i_resume_seq >= r_high);
    assign lost        = (r_wmin != '0) && (r_since < r_wmin - SEQ_W'(1));
    assign match       = r_is_pop || (q_seq > r_since);
    assign consume     = r_pend && (!match || !r_hold_v || i_out_free);
    assign rd          = (r_left != '0) && (!r_pend || consume);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_high     = r_high;
        n_ptr      = r_ptr;
        n_left     = r_left;
        n_pend     = r_pend;
        n_is_pop   = r_is_pop;
        n_since    = r_since;
        n_wmin     = r_wmin;
        n_wmax     = r_wmax;
        n_found    = r_found;
        n_hold_v   = r_hold_v;
        n_hold_seq = r_hold_seq;
        n_hold_pay = r_hold_pay;

        ram_we    = 1'b0;
        ram_waddr = head_p + cnt_p[ADDR_W-1:0];
        ram_wdata = {i_entry_payload, i_entry_seq};
        ram_re    = 1'b0;
        ram_raddr = r_ptr;

        o_emit             = 1'b0;
        o_result           = '0;
        o_result.occupancy = OCC_W'(r_count);

        // Window fields travel on every replay result
        if (!r_is_pop) begin
            o_result.resume_held    = r_found;
            o_result.window_min_seq = r_wmin;
            o_result.window_max_seq = r_wmax;
        end

        case (r_state)
            S_IDLE: begin
                o_result = '0;
                o_result.last      = 1'b1;
                o_result.occupancy = OCC_W'(r_count);
                if (accept) begin
                    case (i_mode)
                        MODE_PUSH: begin
                            ram_we  = 1'b1;
                            n_head  = head_p;
                            n_count = cnt_p + CNT_W'(1);
                            if (i_entry_seq > r_high) begin
                                n_high = i_entry_seq;
                            end
                            o_emit = 1'b1;
                            o_result.stored_without_eviction = !evict;
                            o_result.occupancy = OCC_W'(cnt_p + CNT_W'(1));
                        end
                        MODE_POP: begin
                            n_is_pop = 1'b1;
                            if (take == '0) begin
                                o_emit = 1'b1;
                            end else begin
                                n_ptr   = r_head;
                                n_left  = take;
                                n_head  = r_head + take[ADDR_W-1:0];
                                n_count = r_count - take;
                                n_state = S_SCAN;
                            end
                        end
                        MODE_REPLAY: begin
                            n_is_pop = 1'b0;
                            n_since  = i_resume_seq;
                            if (r_count == '0) begin
                                o_emit = 1'b1;
                                o_result.resume_held    = found_empty;
                                o_result.window_max_seq = found_empty ? '0 : r_high;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_state   = S_WMIN;
                            end
                        end
                        default: begin
                            o_emit = 1'b1;
                        end
                    endcase
                end
            end
            S_WMIN: begin
                n_wmin    = q_seq;
                ram_re    = 1'b1;
                ram_raddr = r_head + cnt_m1[ADDR_W-1:0];
                n_state   = S_WMAX;
            end
            S_WMAX: begin
                n_wmax = q_seq;
                if (r_since == '0) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (lost) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_found = 1'b1;
                    n_ptr   = r_head;
                    n_left  = r_count;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Keep one match in hand so the final result can carry last
                if (consume && match) begin
                    if (r_hold_v) begin
                        o_emit               = 1'b1;
                        o_result.has_entry   = 1'b1;
                        o_result.out_seq     = r_hold_seq;
                        o_result.out_payload = r_hold_pay;
                    end
                    n_hold_v   = 1'b1;
                    n_hold_seq = q_seq;
                    n_hold_pay = q_pay;
                end
                if (rd) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ptr;
                    n_ptr     = r_ptr + ADDR_W'(1);
                    n_left    = r_left - CNT_W'(1);
                end
                n_pend = rd || (r_pend && !consume);
                if ((r_left == '0) && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_emit        = 1'b1;
                    o_result.last = 1'b1;
                    if (r_hold_v) begin
                        o_result.has_entry    = 1'b1;
                        o_result.out_seq      = r_hold_seq;
                        o_result.out_payload  = r_hold_pay;
                        o_result.became_empty = r_is_pop && (r_count == '0);
                    end
                    n_hold_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_high   <= '0;
            r_left   <= '0;
            r_pend   <= 1'b0;
            r_hold_v <= 1'b0;
            r_is_pop <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_high   <= n_high;
            r_left   <= n_left;
            r_pend   <= n_pend;
            r_hold_v <= n_hold_v;
            r_is_pop <= n_is_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_since    <= n_since;
        r_wmin     <= n_wmin;
        r_wmax     <= n_wmax;
        r_found    <= n_found;
        r_hold_seq <= n_hold_seq;
        r_hold_pay <= n_hold_pay;
    end

endmodule

`default_nettype wire

### rtl/core/evicting_event_ring_with_replay_unit.sv
// Event ring with drop-oldest eviction and sequence replay: top level.
// Holds the capacity register, the output word register and the checks.
// Depends on evring_pkg, evring_seq (and evring_ram), the assertion header.
//
// Usage:
//   Input words arrive on the s-side stream; tuser selects push, pop batch,
//   replay or no operation. Result words leave on the m-side stream, tlast
//   marking the final word of each input word, tuser flagging a carried entry.
//   The capacity register sits at APB address 0; the user must write it only
//   while idle. The block itself does not enforce this.
// With the receiver ready: push, no-op, empty pop and replay on an empty ring
//   give one result, in the output register from the cycle after acceptance;
//   a new word is taken every cycle. Pop of n entries gives n results; a pop
//   or replay takes no new word until its last result has been emitted.
//   Replay on a held window: the oldest and newest entries are read; a scan
//   then gives one result per matching entry, or one entry-less result if none
//   match; live-tail or lost replay gives one result. Scans read one entry per
//   cycle through the single RAM read port.
// Reset: ring empty, highest sequence zero, capacity 32; RAM is not cleared.
// Stall: a result waits in the output register; the sequencer holds while
//   it is full and not taken, and no input word is accepted.
`default_nettype none

module evicting_event_ring_with_replay_unit
    import evring_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // APB configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    // Input stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // tdata: entry_seq[63:0], entry_payload[95:64], batch_limit[101:96],
    //        resume_after_seq[165:102], zero[167:166]
    input  wire logic [167:0]          i_s_tdata,
    // tuser: mode[1:0]
    input  wire logic [MODE_W-1:0]     i_s_tuser,
    // Output stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // tdata: out_seq[63:0], out_payload[95:64], stored_without_eviction[96],
    //        resume_held[97], window_min_seq[161:98],
    //        window_max_seq[225:162], became_empty[226], occupancy[232:227],
    //        zero[239:233]
    output logic      [239:0]          o_m_tdata,
    // tuser: has_entry[0]
    output logic                       o_m_tuser,
    output logic                       o_m_tlast
);

`include "evicting_event_ring_with_replay_unit_assert.svh"

    logic [CAP_W-1:0] r_cap;
    logic             cfg_wr;

    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;
    logic             out_free;
    logic             emit;
    t_result          result;

    // Capacity register: written on the APB access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? CFG_DATA_W'(r_cap) : '0;

    // Output register frees up when empty or when its word is taken
    assign out_free = !r_out_valid || i_m_tready;

    evring_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cap           (r_cap),
        .i_in_valid      (i_s_tvalid),
        .o_in_ready      (o_s_tready),
        .i_mode          (i_s_tuser),
        .i_entry_seq     (i_s_tdata[63:0]),
        .i_entry_payload (i_s_tdata[95:64]),
        .i_batch_limit   (i_s_tdata[101:96]),
        .i_resume_seq    (i_s_tdata[165:102]),
        .i_out_free      (out_free),
        .o_emit          (emit),
        .o_result        (result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = result;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.has_entry;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {7'b0,
                         r_out.occupancy,
                         r_out.became_empty,
                         r_out.window_max_seq,
                         r_out.window_min_seq,
                         r_out.resume_held,
                         r_out.stored_without_eviction,
                         r_out.out_payload,
                         r_out.out_seq};

    // A word with no entry always closes its input word
    `EVRING_ASSERT_NOW(a_noentry_is_last, i_clk, i_rst_n,
        r_out_valid && !r_out.has_entry, r_out.last, "entry-less result without tlast")

    // Draining the ring is flagged only on a closing word that leaves it empty
    `EVRING_ASSERT_NOW(a_empty_flag, i_clk, i_rst_n,
        r_out_valid && r_out.became_empty,
        r_out.last && r_out.has_entry && (r_out.occupancy == '0),
        "became_empty on a non-final or non-empty result")

    // Occupancy never passes the ring depth
    `EVRING_ASSERT_NOW(a_occ_bound, i_clk, i_rst_n,
        r_out_valid, r_out.occupancy <= OCC_W'(DEPTH), "occupancy above depth")

    // A capacity write lands in the register
    `EVRING_ASSERT_NEXT(a_cfg_write, i_clk, i_rst_n,
        cfg_wr, r_cap == $past(pwdata[CAP_W-1:0]), "capacity write lost")

endmodule

`default_nettype wire
